/* rtl/assert_macros.svh */
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on each rising clock edge, skipped while reset is held.
`define OLI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on each rising clock edge, reset included.
`define OLI_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/oli_pkg.sv */
// ----------------------------------------------------------------------------
// oli_pkg
// Command codes, status codes and the cell control bundle of the ordered list.
// ----------------------------------------------------------------------------
`default_nettype none

package oli_pkg;

    // Wide enough for any index and count of a list of up to 1024 entries
    localparam int IDX_W = 11;

    typedef enum logic [3:0] {
        CMD_PUSH_BACK  = 4'd0,
        CMD_PUSH_FRONT = 4'd1,
        CMD_POP_BACK   = 4'd2,
        CMD_POP_FRONT  = 4'd3,
        CMD_READ       = 4'd4,
        CMD_WRITE      = 4'd5,
        CMD_INSERT     = 4'd6,
        CMD_ERASE      = 4'd7,
        CMD_CLEAR      = 4'd8
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_ERASE  = 2'd2,
        OP_WRITE  = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [IDX_W-1:0]  pos;
        logic [31:0]       value;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* rtl/oli_cell.sv */
// ----------------------------------------------------------------------------
// oli_cell
// One storage cell of the list: holds one element and trades it with its
// neighbors when an element is inserted or erased ahead of it.
// ----------------------------------------------------------------------------
`default_nettype none

module oli_cell
    import oli_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  wire logic        i_clk,
    input  wire t_cell_ctl   i_ctl,
    input  wire logic [31:0] i_left,   // element of the cell in front
    input  wire logic [31:0] i_right,  // element of the cell behind
    output logic [31:0]      o_data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [31:0] r_data;
    logic [31:0] n_data;
    logic        w_at;
    logic        w_after;

    assign w_at    = (MY_IDX == i_ctl.pos);
    assign w_after = (MY_IDX > i_ctl.pos);

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            OP_INSERT: begin
                // open a gap: later cells take the element in front
                if (w_after) begin
                    n_data = i_left;
                end else if (w_at) begin
                    n_data = i_ctl.value;
                end
            end
            OP_ERASE: begin
                if (w_at || w_after) begin
                    n_data = i_right;
                end
            end
            OP_WRITE: begin
                if (w_at) begin
                    n_data = i_ctl.value;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

/* rtl/ordered_list_insert_erase_unit.sv */
// ----------------------------------------------------------------------------
// ordered_list_insert_erase_unit
// Ordered list of signed 32-bit values held in a row of shifting cells.
// ----------------------------------------------------------------------------
// The unit takes one command per clock cycle while results are taken, and
// returns exactly one result per command, in the cycle after it is accepted.
// All cells update in parallel in the accepting cycle, so insert and erase at
// any position are as cheap as a push or a read. A single output register holds
// the result; while it waits unaccepted the input stalls, and a new request
// enters in the same cycle the waiting result is taken. Element 0 is the front.
// Input tuser carries the command, tdata the position [4:0] and the value
// [36:5]. Output tuser carries the status, tdata the read value [31:0], the
// count [36:32] and the empty flag [37]. Only positions 0 to 31 are reachable.
`default_nettype none

module ordered_list_insert_erase_unit
    import oli_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,  // position[4:0], value[36:5], zero pad
    input  wire logic [3:0]  i_s_tuser,  // command[3:0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata,  // read_value[31:0], count[36:32],
                                         // is_empty[37], zero pad
    output logic [1:0]       o_m_tuser   // status[1:0]
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int RD_N = (CAPACITY < 32) ? CAPACITY : 32;

    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             r_valid;
    logic [39:0]      r_data;
    logic [1:0]       r_user;

    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    logic [4:0]       w_pos;
    logic [31:0]      w_value;
    logic [IDX_W-1:0] w_pos_x;
    logic [IDX_W-1:0] w_cnt_x;
    logic [31:0]      w_rd;
    logic [31:0]      w_rd_sel;
    t_status          w_status;
    t_cell_ctl        w_ctl;
    logic [31:0]      w_cells [CAPACITY];

    // refuse requests while reset is held
    assign o_s_tready = i_rst_n && (!r_valid || i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_pos      = i_s_tdata[4:0];
    assign w_value    = i_s_tdata[36:5];
    assign w_pos_x    = IDX_W'(w_pos);
    assign w_cnt_x    = IDX_W'(r_count);
    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_empty    = (r_count == '0);

    always_comb begin
        w_rd_sel = '0;
        for (int i = 0; i < RD_N; i++) begin
            if (w_pos == 5'(i)) begin
                w_rd_sel = w_cells[i];
            end
        end
    end

    always_comb begin
        n_count   = r_count;
        w_status  = ST_DONE;
        w_rd      = '0;
        w_ctl.op    = OP_HOLD;
        w_ctl.pos   = w_pos_x;
        w_ctl.value = w_value;
        case (t_cmd'(i_s_tuser))
            CMD_PUSH_BACK: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctl.op  = OP_INSERT;
                    w_ctl.pos = w_cnt_x;
                    n_count   = CW'(r_count + 1'b1);
                end
            end
            CMD_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctl.op  = OP_INSERT;
                    w_ctl.pos = '0;
                    n_count   = CW'(r_count + 1'b1);
                end
            end
            CMD_POP_BACK: begin
                if (w_empty) begin
                    w_status = ST_BAD;
                end else begin
                    n_count = CW'(r_count - 1'b1);
                end
            end
            CMD_POP_FRONT: begin
                if (w_empty) begin
                    w_status = ST_BAD;
                end else begin
                    w_ctl.op  = OP_ERASE;
                    w_ctl.pos = '0;
                    n_count   = CW'(r_count - 1'b1);
                end
            end
            CMD_READ: begin
                if (w_pos_x >= w_cnt_x) begin
                    w_status = ST_BAD;
                end else begin
                    w_rd = w_rd_sel;
                end
            end
            CMD_WRITE: begin
                if (w_pos_x >= w_cnt_x) begin
                    w_status = ST_BAD;
                end else begin
                    w_ctl.op = OP_WRITE;
                end
            end
            CMD_INSERT: begin
                // position check comes before the full check
                if (w_pos_x > w_cnt_x) begin
                    w_status = ST_BAD;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctl.op = OP_INSERT;
                    n_count  = CW'(r_count + 1'b1);
                end
            end
            CMD_ERASE: begin
                if (w_pos_x >= w_cnt_x) begin
                    w_status = ST_BAD;
                end else begin
                    w_ctl.op = OP_ERASE;
                    n_count  = CW'(r_count - 1'b1);
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        // cells hold unless a request is actually taken
        if (!w_accept) begin
            w_ctl.op = OP_HOLD;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [31:0] w_left;
        logic [31:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = w_value;
        end else begin : g_mid
            assign w_left = w_cells[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_cells[g];
        end else begin : g_inner
            assign w_right = w_cells[g+1];
        end
        oli_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_cells[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data <= {2'b00, (n_count == '0), 5'(n_count), w_rd};
            r_user <= w_status;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tuser  = r_user;

endmodule

`default_nettype wire

/* rtl/oli_checker.sv */
// ----------------------------------------------------------------------------
// oli_checker
// Port-level checks on the results of the ordered list unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module oli_checker
    import oli_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [39:0] o_m_tdata,
    input  wire logic [1:0]  o_m_tuser
);

    localparam logic [4:0] CAP_LOW = 5'(CAPACITY);
    localparam logic       WIDE    = (CAPACITY > 31);

    // hold a stalled result
    `OLI_ASSERT(a_hold_result, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "result changed while stalled")

    // empty flag must agree with the count (checked for capacities below 32)
    `OLI_ASSERT(a_empty_flag, i_clk, i_rst_n, o_m_tvalid && !WIDE |-> (o_m_tdata[37] == (o_m_tdata[36:32] == 5'd0)), "empty flag disagrees with count")

    // a full report leaves the list at capacity
    `OLI_ASSERT(a_full_count, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == ST_FULL) |-> (o_m_tdata[36:32] == CAP_LOW) && !o_m_tdata[37], "full status with count below capacity")

    // only a completed read returns data
    `OLI_ASSERT(a_read_ok, i_clk, i_rst_n, o_m_tvalid && (o_m_tdata[31:0] != 32'd0) |-> (o_m_tuser == ST_DONE), "read value on a failed request")

    // no result out of reset
    `OLI_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_m_tvalid, "result valid right after reset")

endmodule

bind ordered_list_insert_erase_unit oli_checker #(
    .CAPACITY (CAPACITY)
) u_oli_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire

/* tb/oli_list_checker.sv */
// ----------------------------------------------------------------------------
// oli_list_checker
// Watches both streams of the ordered list unit, predicts every result from
// accepted requests with its own copy of the list, and compares field by field.
// ----------------------------------------------------------------------------

module oli_list_checker
    import oli_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,   // position[4:0], value[36:5], zero pad
    input  logic [3:0]  i_s_tuser,   // command[3:0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,   // read_value[31:0], count[36:32],
                                     // is_empty[37], zero pad
    input  logic [1:0]  i_m_tuser,   // status[1:0]
    output int          o_errors,
    output int          o_pending,
    output int          o_checked,
    output int          o_full_seen,
    output int          o_bad_seen
);

    typedef struct packed {
        logic [31:0] rd_value;
        logic [4:0]  count;
        logic        empty;
        t_status     status;
    } t_list_result;

    logic [31:0]  elems [CAPACITY];
    int unsigned  elem_count = 0;
    t_list_result result_q[$];

    int err_cnt  = 0;
    int pend_cnt = 0;
    int chk_cnt  = 0;
    int full_cnt = 0;
    int bad_cnt  = 0;

    assign o_errors    = err_cnt;
    assign o_pending   = pend_cnt;
    assign o_checked   = chk_cnt;
    assign o_full_seen = full_cnt;
    assign o_bad_seen  = bad_cnt;

    // Apply one request to the shadow list and return the result it produces.
    function automatic t_list_result list_apply(logic [3:0] cmd, logic [4:0] pos,
                                                logic [31:0] val);
        t_list_result r;
        int unsigned  p;
        int unsigned  i;
        r.rd_value = '0;
        r.status   = ST_DONE;
        p          = pos;
        case (cmd)
            CMD_PUSH_BACK: begin
                if (elem_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    elems[elem_count] = val;
                    elem_count++;
                end
            end
            CMD_PUSH_FRONT: begin
                if (elem_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = elem_count; i > 0; i--) elems[i] = elems[i-1];
                    elems[0] = val;
                    elem_count++;
                end
            end
            CMD_POP_BACK: begin
                if (elem_count == 0) r.status = ST_BAD;
                else elem_count--;
            end
            CMD_POP_FRONT: begin
                if (elem_count == 0) begin
                    r.status = ST_BAD;
                end else begin
                    for (i = 0; i + 1 < elem_count; i++) elems[i] = elems[i+1];
                    elem_count--;
                end
            end
            CMD_READ: begin
                if (p >= elem_count) r.status = ST_BAD;
                else r.rd_value = elems[p];
            end
            CMD_WRITE: begin
                if (p >= elem_count) r.status = ST_BAD;
                else elems[p] = val;
            end
            CMD_INSERT: begin
                // position check wins over the full check
                if (p > elem_count) begin
                    r.status = ST_BAD;
                end else if (elem_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = elem_count; i > p; i--) elems[i] = elems[i-1];
                    elems[p] = val;
                    elem_count++;
                end
            end
            CMD_ERASE: begin
                if (p >= elem_count) begin
                    r.status = ST_BAD;
                end else begin
                    for (i = p; i + 1 < elem_count; i++) elems[i] = elems[i+1];
                    elem_count--;
                end
            end
            CMD_CLEAR: elem_count = 0;
            default: ;
        endcase
        r.count = elem_count[4:0];
        r.empty = (elem_count == 0);
        return r;
    endfunction

    task automatic note_mismatch(string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    // Sample at the falling edge: the handshake seen here completes at the next
    // rising edge, and nothing the testbench drives changes in between.
    always @(negedge i_clk) begin
        t_list_result want;
        t_list_result got;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                got.rd_value = i_m_tdata[31:0];
                got.count    = i_m_tdata[36:32];
                got.empty    = i_m_tdata[37];
                got.status   = t_status'(i_m_tuser);
                chk_cnt++;
                if (got.status == ST_FULL) full_cnt++;
                if (got.status == ST_BAD) bad_cnt++;
                if (result_q.size() == 0) begin
                    note_mismatch($sformatf("unexpected result rd=%h cnt=%0d empty=%0b st=%0d",
                        got.rd_value, got.count, got.empty, got.status));
                end else begin
                    // oldest prediction sits at the head
                    want = result_q[0];
                    result_q.delete(0);
                    if (got.rd_value !== want.rd_value || got.count !== want.count ||
                        got.empty !== want.empty || got.status !== want.status) begin
                        note_mismatch($sformatf(
                            {"result %0d: exp rd=%h cnt=%0d empty=%0b st=%0d, ",
                             "got rd=%h cnt=%0d empty=%0b st=%0d"},
                            chk_cnt, want.rd_value, want.count, want.empty, want.status,
                            got.rd_value, got.count, got.empty, got.status));
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                result_q.insert(result_q.size(),
                                list_apply(i_s_tuser, i_s_tdata[4:0], i_s_tdata[36:5]));
            end
            pend_cnt = result_q.size();
        end
    end

endmodule

/* tb/ordered_list_insert_erase_unit_tb.sv */
// ----------------------------------------------------------------------------
// ordered_list_insert_erase_unit_tb
// Drives requests into the ordered list unit: a directed pass over empty,
// boundary and unused-command cases, then random grow and shrink runs under
// three sender/receiver stall mixes. A checker module predicts and compares.
// ----------------------------------------------------------------------------

module ordered_list_insert_erase_unit_tb;
    import oli_pkg::*;

    localparam int          LIST_CAP      = 16;
    localparam logic [3:0]  CMD_UNUSED_LO = 4'd9;
    localparam logic [3:0]  CMD_UNUSED_HI = 4'd15;
    localparam int          RANDOM_PER_PHASE = 130;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata    = '0;   // position[4:0], value[36:5], zero pad
    logic [3:0]  s_tuser    = '0;   // command[3:0]
    logic        m_tvalid;
    logic        m_tready   = 1'b0;
    logic [39:0] m_tdata;           // read_value[31:0], count[36:32], is_empty[37]
    logic [1:0]  m_tuser;           // status[1:0]

    int errors, pending, checked, full_seen, bad_seen;
    int send_idle_pct = 34;
    int recv_idle_pct = 82;
    int requests_sent = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    ordered_list_insert_erase_unit #(.CAPACITY(LIST_CAP)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    oli_list_checker #(.CAPACITY(LIST_CAP)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_full_seen (full_seen),
        .o_bad_seen  (bad_seen)
    );

    // Stall the result side at random.
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Call at a rising edge; returns at the rising edge that accepts the request.
    task automatic issue_request(logic [3:0] cmd, logic [4:0] pos, logic [31:0] val);
        logic fired;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, val, pos};
        do begin
            @(negedge i_clk);
            fired = s_tready;
            @(posedge i_clk);
        end while (!fired);
        requests_sent++;
    endtask

    function automatic logic [3:0] pick_cmd(bit grow);
        int unsigned r;
        r = $urandom_range(99);
        if (r >= 98) return 4'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
        if (r >= 96) return CMD_CLEAR;
        if (grow) begin
            if (r < 25) return CMD_PUSH_BACK;
            if (r < 45) return CMD_PUSH_FRONT;
            if (r < 68) return CMD_INSERT;
            if (r < 78) return CMD_READ;
            if (r < 86) return CMD_WRITE;
            if (r < 90) return CMD_ERASE;
            if (r < 93) return CMD_POP_BACK;
            return CMD_POP_FRONT;
        end
        if (r < 15) return CMD_POP_BACK;
        if (r < 30) return CMD_POP_FRONT;
        if (r < 52) return CMD_ERASE;
        if (r < 67) return CMD_READ;
        if (r < 77) return CMD_WRITE;
        if (r < 83) return CMD_PUSH_BACK;
        if (r < 88) return CMD_PUSH_FRONT;
        return CMD_INSERT;
    endfunction

    function automatic logic [4:0] pick_pos();
        if ($urandom_range(99) < 85) return 5'($urandom_range(16));
        return 5'($urandom_range(31, 17));
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(11))
            0: return 32'h0000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    initial begin
        bit grow;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list: every guarded command must be rejected
        issue_request(CMD_POP_BACK,  5'd0, 32'h0);
        issue_request(CMD_POP_FRONT, 5'd0, 32'h0);
        issue_request(CMD_READ,      5'd0, 32'h0);
        issue_request(CMD_WRITE,     5'd0, 32'h1111_1111);
        issue_request(CMD_ERASE,     5'd0, 32'h0);
        issue_request(CMD_INSERT,    5'd1, 32'h2222_2222);
        // insert at count appends
        issue_request(CMD_INSERT,     5'd0, 32'h1234_5678);
        issue_request(CMD_PUSH_BACK,  5'd0, 32'h7fff_ffff);
        issue_request(CMD_PUSH_FRONT, 5'd0, 32'h8000_0000);
        issue_request(CMD_PUSH_BACK,  5'd0, 32'hffff_ffff);
        issue_request(CMD_INSERT,     5'd4, 32'h0000_0000);
        issue_request(CMD_INSERT,     5'd2, 32'h0000_0001);
        issue_request(CMD_READ,       5'd0, 32'h0);
        issue_request(CMD_READ,       5'd5, 32'h0);
        issue_request(CMD_READ,       5'd6, 32'h0);
        issue_request(CMD_READ,       5'd31, 32'hffff_ffff);
        issue_request(CMD_WRITE,      5'd1, 32'ha5a5_a5a5);
        issue_request(CMD_READ,       5'd1, 32'h0);
        issue_request(CMD_ERASE,      5'd2, 32'h0);
        issue_request(CMD_ERASE,      5'd4, 32'h0);
        issue_request(CMD_POP_FRONT,  5'd0, 32'h0);
        issue_request(CMD_POP_BACK,   5'd0, 32'h0);
        issue_request(CMD_UNUSED_LO,  5'd31, 32'hdead_beef);
        issue_request(CMD_UNUSED_HI,  5'd16, 32'h0);
        issue_request(CMD_CLEAR,      5'd0, 32'h0);

        // alternate grow and shrink runs so the list hits full and empty often
        grow = 1'b1;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 34; recv_idle_pct = 82; end
                1: begin send_idle_pct = 82; recv_idle_pct = 34; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                if (k % 30 == 0) grow = ~grow;
                issue_request(pick_cmd(grow), pick_pos(), pick_value());
            end
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Sent %0d requests under three stall mixes; checked %0d results", requests_sent,
                 checked);
        $display("Rejections seen: %0d full, %0d bad position or empty", full_seen, bad_seen);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/oli_pkg.sv
rtl/oli_cell.sv
rtl/ordered_list_insert_erase_unit.sv
rtl/oli_checker.sv
tb/oli_list_checker.sv
tb/ordered_list_insert_erase_unit_tb.sv
